@@ sv/nvts_pkg.sv @@
// ----------------------------------------------------------------------------
// nvts_pkg
// shared types and constants of the nearest value table search
// ----------------------------------------------------------------------------
package nvts_pkg;

    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 8;
    localparam int RESULT_W = 9;
    localparam int SIZE_W   = 9;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // register word index taken from paddr[2]
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST_CK,
        ST_FIRST_CK,
        ST_LOOP,
        ST_MID_CK,
        ST_NB_CK,
        ST_NEAR,
        ST_DONE
    } t_state;

endpackage

@@ sv/nvts_req_if.sv @@
// ----------------------------------------------------------------------------
// nvts_req_if
// request channel: table write or nearest value search
// ----------------------------------------------------------------------------
interface nvts_req_if;

    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [nvts_pkg::ENTRY_W-1:0]        entry_index;
    logic signed [nvts_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output entry_index, output value,
                    input ready);
    modport sink   (input valid, input operation, input entry_index, input value,
                    output ready);

endinterface

@@ sv/nvts_rsp_if.sv @@
// ----------------------------------------------------------------------------
// nvts_rsp_if
// response channel: index of the nearest entry
// ----------------------------------------------------------------------------
interface nvts_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [nvts_pkg::RESULT_W-1:0] result_index;
    logic                          not_found;

    modport source (output valid, output result_index, output not_found, input ready);
    modport sink   (input valid, input result_index, input not_found, output ready);

endinterface

@@ sv/nvts_ram.sv @@
// ----------------------------------------------------------------------------
// nvts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module nvts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/nvts_cfg.sv @@
// ----------------------------------------------------------------------------
// nvts_cfg
// apb register file holding the table size
// ----------------------------------------------------------------------------
module nvts_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nvts_pkg::APB_AW-1:0] paddr,
    input  logic [nvts_pkg::APB_DW-1:0] pwdata,
    output logic [nvts_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [nvts_pkg::SIZE_W-1:0] o_table_size
);

    logic [nvts_pkg::SIZE_W-1:0] r_table_size;
    logic                        wr_size;

    assign wr_size = psel && penable && pwrite && (paddr[2] == nvts_pkg::REG_TABLE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= nvts_pkg::SIZE_RESET;
        end else if (wr_size) begin
            r_table_size <= pwdata[nvts_pkg::SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == nvts_pkg::REG_TABLE_SIZE) begin
            prdata = nvts_pkg::APB_DW'(r_table_size);
        end
    end

    assign pready       = 1'b1;
    assign o_table_size = r_table_size;

endmodule

@@ sv/nvts_ctrl.sv @@
// ----------------------------------------------------------------------------
// nvts_ctrl
// search sequencer: reads the table ram one entry per cycle, narrows the
// bracket and holds the response in an output register
// ----------------------------------------------------------------------------
module nvts_ctrl #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [nvts_pkg::SIZE_W-1:0]         i_table_size,
    nvts_req_if.sink                            i_req,
    nvts_rsp_if.source                          o_rsp,
    output logic                                o_ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_ram_waddr,
    output logic [nvts_pkg::VALUE_W-1:0]        o_ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_ram_raddr,
    input  logic [nvts_pkg::VALUE_W-1:0]        i_ram_rdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 2;
    localparam int DW = nvts_pkg::VALUE_W + 1;

    nvts_pkg::t_state r_state, n_state;

    logic signed [CW-1:0]                r_lo, n_lo;
    logic signed [CW-1:0]                r_hi, n_hi;
    logic signed [CW-1:0]                r_mid, n_mid;
    logic signed [CW-1:0]                r_n, n_n;
    logic signed [CW-1:0]                r_pair, n_pair;
    logic signed [nvts_pkg::VALUE_W-1:0] r_x, n_x;
    logic signed [nvts_pkg::VALUE_W-1:0] r_m, n_m;
    logic signed [DW-1:0]                r_d_up, n_d_up;
    logic signed [DW-1:0]                r_d_lo, n_d_lo;
    logic                                r_dir_down, n_dir_down;
    logic [nvts_pkg::RESULT_W-1:0]       r_res_idx, n_res_idx;
    logic                                r_res_nf, n_res_nf;

    logic                                r_out_vld;
    logic [nvts_pkg::RESULT_W-1:0]       r_out_idx;
    logic                                r_out_nf;

    logic signed [CW-1:0]                size_eff;
    logic signed [CW-1:0]                mid_calc;
    logic signed [nvts_pkg::VALUE_W-1:0] rd;
    logic                                acc;
    logic                                out_load;
    logic                                x_lt_rd;
    logic                                x_gt_rd;
    logic                                loop_go;
    logic                                nb_hit;

    assign rd       = $signed(i_ram_rdata);
    assign x_lt_rd  = r_x < rd;
    assign x_gt_rd  = r_x > rd;
    assign acc      = i_req.valid && i_req.ready;
    assign out_load = (r_state == nvts_pkg::ST_DONE) && (!r_out_vld || o_rsp.ready);
    assign mid_calc = (r_lo + r_hi) >>> 1;
    assign loop_go  = r_lo < r_hi;
    assign nb_hit   = r_dir_down ? x_gt_rd : x_lt_rd;

    // table size limited to the range 1 .. depth
    always_comb begin
        if (int'(i_table_size) > TABLE_DEPTH) begin
            size_eff = CW'(TABLE_DEPTH);
        end else if (i_table_size == '0) begin
            size_eff = CW'(1);
        end else begin
            size_eff = CW'(i_table_size);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nvts_pkg::ST_IDLE: begin
                if (acc && (i_req.operation == nvts_pkg::OP_SEARCH)) begin
                    n_state = nvts_pkg::ST_LAST_CK;
                end
            end
            nvts_pkg::ST_LAST_CK: begin
                n_state = x_gt_rd ? nvts_pkg::ST_FIRST_CK : nvts_pkg::ST_DONE;
            end
            nvts_pkg::ST_FIRST_CK: begin
                n_state = x_lt_rd ? nvts_pkg::ST_LOOP : nvts_pkg::ST_DONE;
            end
            nvts_pkg::ST_LOOP: begin
                n_state = loop_go ? nvts_pkg::ST_MID_CK : nvts_pkg::ST_DONE;
            end
            nvts_pkg::ST_MID_CK: begin
                if (x_lt_rd) begin
                    n_state = (r_mid < r_hi) ? nvts_pkg::ST_NB_CK : nvts_pkg::ST_LOOP;
                end else if (x_gt_rd) begin
                    n_state = (r_mid > 0) ? nvts_pkg::ST_NB_CK : nvts_pkg::ST_LOOP;
                end else begin
                    n_state = nvts_pkg::ST_DONE;
                end
            end
            nvts_pkg::ST_NB_CK: begin
                n_state = nb_hit ? nvts_pkg::ST_NEAR : nvts_pkg::ST_LOOP;
            end
            nvts_pkg::ST_NEAR: begin
                n_state = nvts_pkg::ST_DONE;
            end
            nvts_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = nvts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nvts_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_n        = r_n;
        n_pair     = r_pair;
        n_x        = r_x;
        n_m        = r_m;
        n_d_up     = r_d_up;
        n_d_lo     = r_d_lo;
        n_dir_down = r_dir_down;
        n_res_idx  = r_res_idx;
        n_res_nf   = r_res_nf;
        o_ram_raddr = AW'(r_mid);
        o_ram_we    = 1'b0;
        case (r_state)
            nvts_pkg::ST_IDLE: begin
                o_ram_we    = acc && (i_req.operation == nvts_pkg::OP_WRITE)
                              && (int'(i_req.entry_index) < TABLE_DEPTH);
                o_ram_raddr = AW'(size_eff - CW'(1));
                n_x         = i_req.value;
                n_n         = size_eff;
                n_lo        = '0;
                n_hi        = size_eff - CW'(1);
                n_res_nf    = 1'b0;
            end
            nvts_pkg::ST_LAST_CK: begin
                o_ram_raddr = '0;
                n_res_idx   = nvts_pkg::RESULT_W'(r_hi);
            end
            nvts_pkg::ST_FIRST_CK: begin
                n_res_idx = '0;
            end
            nvts_pkg::ST_LOOP: begin
                n_mid       = mid_calc;
                o_ram_raddr = AW'(mid_calc);
                n_res_idx   = nvts_pkg::RESULT_W'(r_n);
                n_res_nf    = !loop_go;
            end
            nvts_pkg::ST_MID_CK: begin
                n_m       = rd;
                n_res_idx = nvts_pkg::RESULT_W'(r_mid);
                if (x_lt_rd) begin
                    n_dir_down  = 1'b1;
                    o_ram_raddr = AW'(r_mid + CW'(1));
                    n_lo        = r_mid + CW'(1);
                end else if (x_gt_rd) begin
                    n_dir_down  = 1'b0;
                    o_ram_raddr = AW'(r_mid - CW'(1));
                    n_hi        = r_mid - CW'(1);
                end
            end
            nvts_pkg::ST_NB_CK: begin
                if (r_dir_down) begin
                    n_pair = r_mid;
                    n_d_up = DW'(r_m) - DW'(r_x);
                    n_d_lo = DW'(r_x) - DW'(rd);
                end else begin
                    n_pair = r_mid - CW'(1);
                    n_d_up = DW'(rd) - DW'(r_x);
                    n_d_lo = DW'(r_x) - DW'(r_m);
                end
            end
            nvts_pkg::ST_NEAR: begin
                if (r_d_up >= r_d_lo) begin
                    n_res_idx = nvts_pkg::RESULT_W'(r_pair + CW'(1));
                end else begin
                    n_res_idx = nvts_pkg::RESULT_W'(r_pair);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ram_waddr = AW'(i_req.entry_index);
    assign o_ram_wdata = i_req.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nvts_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_n        <= n_n;
        r_pair     <= n_pair;
        r_x        <= n_x;
        r_m        <= n_m;
        r_d_up     <= n_d_up;
        r_d_lo     <= n_d_lo;
        r_dir_down <= n_dir_down;
        r_res_idx  <= n_res_idx;
        r_res_nf   <= n_res_nf;
        if (out_load) begin
            r_out_idx <= r_res_idx;
            r_out_nf  <= r_res_nf;
        end
    end

    assign i_req.ready        = (r_state == nvts_pkg::ST_IDLE);
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.result_index = r_out_idx;
    assign o_rsp.not_found    = r_out_nf;

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nvts_pkg::ST_IDLE) |-> !o_ram_we)
        else $error("table write while a search is running");

    a_mid_in_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nvts_pkg::ST_MID_CK) |-> (r_mid >= r_lo) && (r_mid <= r_hi))
        else $error("probe outside the search bracket");

    a_hi_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nvts_pkg::ST_LOOP) |-> (r_hi < r_n) && (r_lo >= 0))
        else $error("search bracket left the entries in use");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nvts_pkg::ST_DONE) && !out_load |=> (r_state == nvts_pkg::ST_DONE))
        else $error("finished result dropped while output is full");

endmodule

@@ sv/nearest_value_table_search.sv @@
// ----------------------------------------------------------------------------
// nearest_value_table_search
// descending value table with a binary search for the nearest entry
//
//   port    dir  modport  moves
//   i_req   in   sink     table write or search request
//   o_rsp   out  source   nearest index and not found flag, one per search
//   apb     in   -        table_size register at byte address 0
//
// a write request goes into the table ram when it is taken in idle
// a search checks the last and the first entry, then repeats halving steps
// of a probe and a neighbour check, then picks the nearer entry; no new
// request is taken until idle, paced by the single read port of the table ram
// reset sets table_size to 256, table contents stay undefined until written
// a new request is taken while a response waits in the output register,
// a second finished search waits until that response is taken
// ----------------------------------------------------------------------------
module nearest_value_table_search #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    nvts_req_if.sink                    i_req,
    nvts_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nvts_pkg::APB_AW-1:0] paddr,
    input  logic [nvts_pkg::APB_DW-1:0] pwdata,
    output logic [nvts_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [nvts_pkg::SIZE_W-1:0]  table_size;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [nvts_pkg::VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [nvts_pkg::VALUE_W-1:0] ram_rdata;

    nvts_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_table_size (table_size)
    );

    nvts_ram #(
        .WIDTH (nvts_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    nvts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_table_size (table_size),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

endmodule
